// ===== design/swem_pkg.sv =====
// Shared constants and field widths for the sliding-window event meter.
package swem_pkg;

    // Field widths of the item, result and configuration beats.
    localparam int FUNC_W      = 2;
    localparam int TS_W        = 48;
    localparam int AMT_W       = 32;
    localparam int TOT_W       = 64;
    localparam int BKT_REG_W   = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 48;

    // Step counter of the bit-serial divider.
    localparam int DIV_CNT_W   = $clog2(TS_W);

    // Operation codes carried in func.
    localparam logic [FUNC_W-1:0] FUNC_ADD     = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE    = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKETS_IN_USE = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [TS_W-1:0]      WINDOW_RESET  = 48'd1000;
    localparam logic [BKT_REG_W-1:0] BUCKETS_RESET = 5'd16;

endpackage

// ===== design/swem_item_if.sv =====
// Valid/ready channel that carries one meter item per beat.
interface swem_item_if import swem_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [TS_W-1:0]   timestamp;
    logic [AMT_W-1:0]  amount;

    modport source (output valid, output func, output timestamp, output amount, input ready);
    modport sink   (input valid, input func, input timestamp, input amount, output ready);
endinterface

// ===== design/swem_result_if.sv =====
// Valid/ready channel that carries one window total per beat.
interface swem_result_if import swem_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [TOT_W-1:0] window_total;

    modport source (output valid, output window_total, input ready);
    modport sink   (input valid, input window_total, output ready);
endinterface

// ===== design/sliding_window_event_meter_core.sv =====
// Sliding-window event meter: a ring of buckets that counts events over a time window.
//
// One item is worked on at a time. An add runs one bit-serial divider, one
// quotient bit a cycle, twice (window / buckets, then timestamp / bucket width,
// with the bucket index and epoch start falling out of the same pass), and then
// the bucket memory is walked through its single read port, one bucket a cycle,
// expiring, updating and summing. An advance or a query with an unknown code
// skips the divider and only walks the buckets; a clear goes straight to the
// done step. The next item is taken as soon as the total has been placed in the
// output register. Writing either configuration register empties all buckets
// at once.
module sliding_window_event_meter_core import swem_pkg::*; #(
    parameter int MAX_BUCKETS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    swem_item_if.sink             item,
    swem_result_if.source         result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Width of a bucket number (0..MAX_BUCKETS) and of a bucket index.
    localparam int NW = $clog2(MAX_BUCKETS + 1);
    localparam int IW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int CW = (NW > BKT_REG_W) ? NW : BKT_REG_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV_W = 5'b00010,
        S_DIV_E = 5'b00100,
        S_WALK  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;

    // Configuration registers.
    logic [TS_W-1:0]        window_reg;
    logic [BKT_REG_W-1:0]   buckets_reg;

    // Item held for the whole sequence.
    logic [FUNC_W-1:0]      func_reg;
    logic [TS_W-1:0]        now_reg;
    logic [AMT_W-1:0]       amount_reg;
    logic [TS_W-1:0]        win_reg;
    logic [NW-1:0]          n_reg;

    // Divider state and its results.
    logic [TS_W-1:0]        div_rem_reg, div_rem_next;
    logic [TS_W-1:0]        div_quo_reg, div_quo_next;
    logic [NW-1:0]          div_mod_reg, div_mod_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    logic [TS_W-1:0]        width_reg;
    logic [TS_W-1:0]        start_q_reg;
    logic [IW-1:0]          hit_idx_reg;

    // Bucket store: memory plus one valid bit per entry.
    logic [TS_W-1:0]        bucket_start_mem [MAX_BUCKETS];
    logic [TOT_W-1:0]       bucket_count_mem [MAX_BUCKETS];
    logic [MAX_BUCKETS-1:0] bucket_vld_reg;

    // Walk pipeline.
    logic [NW-1:0]          rd_ptr_reg;
    logic                   p1_vld_reg;
    logic [IW-1:0]          p1_idx_reg;
    logic [TS_W-1:0]        start_rd_reg;
    logic [TOT_W-1:0]       count_rd_reg;
    logic                   vld_rd_reg;
    logic                   p2_vld_reg;
    logic [TOT_W-1:0]       p2_cnt_reg;
    logic [TOT_W-1:0]       total_reg;

    // Output register.
    logic                   out_vld_reg;
    logic [TOT_W-1:0]       out_total_reg;

    logic                   accept;
    logic                   out_load;
    logic [CW-1:0]          bk_ext;
    logic [CW-1:0]          n_clamp;
    logic [NW-1:0]          n_eff;
    logic [TS_W-1:0]        win_eff;
    logic [TS_W-1:0]        divisor;
    logic [TS_W:0]          shifted;
    logic                   ge;
    logic [NW:0]            mod_shift;
    logic                   div_last;
    logic                   rd_en;
    logic                   walk_done;
    logic                   wr_en;
    logic [TS_W-1:0]        start_v;
    logic [TOT_W-1:0]       count_v;
    logic [TS_W:0]          expire_at;
    logic                   expired;
    logic                   hit;
    logic [TS_W-1:0]        new_start;
    logic [TOT_W-1:0]       new_count;
    logic                   clear_all;

    assign accept      = item.valid && item.ready;
    assign item.ready  = (state_reg == S_IDLE);
    assign result.valid        = out_vld_reg;
    assign result.window_total = out_total_reg;
    assign out_load    = (state_reg == S_DONE) && (!out_vld_reg || result.ready);

    // Effective window and bucket count from the configuration registers.
    always_comb
    begin
        bk_ext  = CW'(buckets_reg);
        n_clamp = bk_ext;
        if (bk_ext == '0)
        begin
            n_clamp = CW'(1);
        end
        else if (bk_ext > CW'(MAX_BUCKETS))
        begin
            n_clamp = CW'(MAX_BUCKETS);
        end
        n_eff   = NW'(n_clamp);
        win_eff = (window_reg == '0) ? TS_W'(1) : window_reg;
    end

    // Shared divider step: one quotient bit, plus the quotient modulo the bucket count.
    always_comb
    begin
        divisor      = (state_reg == S_DIV_W) ? TS_W'(n_reg) : width_reg;
        shifted      = {div_rem_reg, div_quo_reg[TS_W-1]};
        ge           = (shifted >= {1'b0, divisor});
        div_rem_next = ge ? TS_W'(shifted - {1'b0, divisor}) : shifted[TS_W-1:0];
        div_quo_next = {div_quo_reg[TS_W-2:0], ge};
        mod_shift    = {div_mod_reg, ge};
        div_mod_next = (mod_shift >= {1'b0, n_reg}) ? NW'(mod_shift - {1'b0, n_reg})
                                                    : mod_shift[NW-1:0];
        div_last     = (div_cnt_reg == DIV_CNT_W'(TS_W - 1));
    end

    // Bucket update: expire, then restart and add on the hit bucket.
    // Only an add or an advance retires old buckets; a query sums them as they are.
    always_comb
    begin
        start_v   = vld_rd_reg ? start_rd_reg : '0;
        count_v   = vld_rd_reg ? count_rd_reg : '0;
        expire_at = {1'b0, start_v} + {1'b0, win_reg};
        expired   = ((func_reg == FUNC_ADD) || (func_reg == FUNC_ADVANCE)) &&
                    ({1'b0, now_reg} >= expire_at);
        hit       = (func_reg == FUNC_ADD) && (p1_idx_reg == hit_idx_reg);
        if (hit)
        begin
            new_start = start_q_reg;
            new_count = (expired || (start_v != start_q_reg))
                        ? TOT_W'(amount_reg) : count_v + TOT_W'(amount_reg);
        end
        else
        begin
            new_start = expired ? '0 : start_v;
            new_count = expired ? '0 : count_v;
        end
        wr_en = (state_reg == S_WALK) && p1_vld_reg &&
                ((func_reg == FUNC_ADD) || (func_reg == FUNC_ADVANCE));
    end

    assign rd_en     = (state_reg == S_WALK) && (rd_ptr_reg < n_reg);
    assign walk_done = !rd_en && !p1_vld_reg && !p2_vld_reg;
    assign clear_all = cfg_we || (accept && (item.func == FUNC_CLEAR));

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.func)
                        FUNC_ADD:   state_next = S_DIV_W;
                        FUNC_CLEAR: state_next = S_DONE;
                        default:    state_next = S_WALK;
                    endcase
                end
            end
            S_DIV_W:
            begin
                if (div_last)
                begin
                    state_next = S_DIV_E;
                end
            end
            S_DIV_E:
            begin
                if (div_last)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (walk_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            window_reg     <= WINDOW_RESET;
            buckets_reg    <= BUCKETS_RESET;
            bucket_vld_reg <= '0;
            div_cnt_reg    <= '0;
            rd_ptr_reg     <= '0;
            p1_vld_reg     <= 1'b0;
            p2_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Configuration writes.
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_WINDOW_LENGTH:  window_reg  <= cfg_data;
                    CFG_BUCKETS_IN_USE: buckets_reg <= cfg_data[BKT_REG_W-1:0];
                    default:            ;
                endcase
            end

            // Valid bits: a clear wins over a write-back.
            if (clear_all)
            begin
                bucket_vld_reg <= '0;
            end
            else if (wr_en)
            begin
                bucket_vld_reg[p1_idx_reg] <= 1'b1;
            end

            // Divider step count.
            if ((state_reg == S_DIV_W) || (state_reg == S_DIV_E))
            begin
                div_cnt_reg <= div_last ? '0 : div_cnt_reg + 1'b1;
            end
            else
            begin
                div_cnt_reg <= '0;
            end

            // Walk pointer and pipeline valids.
            if (state_reg == S_WALK)
            begin
                if (rd_en)
                begin
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
                end
            end
            else
            begin
                rd_ptr_reg <= '0;
            end
            p1_vld_reg <= rd_en;
            p2_vld_reg <= p1_vld_reg && (state_reg == S_WALK);

            // Output register.
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg   <= item.func;
            now_reg    <= item.timestamp;
            amount_reg <= item.amount;
            win_reg    <= win_eff;
            n_reg      <= n_eff;
            total_reg  <= '0;
            div_quo_reg <= win_eff;
            div_rem_reg <= '0;
            div_mod_reg <= '0;
        end
        else if (state_reg == S_DIV_W)
        begin
            if (div_last)
            begin
                width_reg   <= (div_quo_next == '0) ? TS_W'(1) : div_quo_next;
                div_quo_reg <= now_reg;
                div_rem_reg <= '0;
                div_mod_reg <= '0;
            end
            else
            begin
                div_quo_reg <= div_quo_next;
                div_rem_reg <= div_rem_next;
                div_mod_reg <= div_mod_next;
            end
        end
        else if (state_reg == S_DIV_E)
        begin
            div_quo_reg <= div_quo_next;
            div_rem_reg <= div_rem_next;
            div_mod_reg <= div_mod_next;
            if (div_last)
            begin
                // Epoch start is the timestamp less its remainder by the width.
                start_q_reg <= now_reg - div_rem_next;
                hit_idx_reg <= div_mod_next[IW-1:0];
            end
        end

        // Walk: index of the bucket in flight and the running sum.
        p1_idx_reg <= rd_ptr_reg[IW-1:0];
        vld_rd_reg <= bucket_vld_reg[rd_ptr_reg[IW-1:0]];
        p2_cnt_reg <= new_count;
        if (p2_vld_reg)
        begin
            total_reg <= total_reg + p2_cnt_reg;
        end
        if (out_load)
        begin
            out_total_reg <= total_reg;
        end
    end

    // Bucket memory: one registered read port, one write port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            start_rd_reg <= bucket_start_mem[rd_ptr_reg[IW-1:0]];
            count_rd_reg <= bucket_count_mem[rd_ptr_reg[IW-1:0]];
        end
        if (wr_en)
        begin
            bucket_start_mem[p1_idx_reg] <= new_start;
            bucket_count_mem[p1_idx_reg] <= new_count;
        end
    end

`ifndef NO_ASSERTIONS
    // A result beat only appears after the sequencer finished an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the done step");

    // A configuration write empties every bucket.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (bucket_vld_reg == '0))
        else $error("buckets still valid after a configuration write");

    // The walk never runs past the latched bucket count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (rd_ptr_reg <= n_reg))
        else $error("walk pointer beyond bucket count");

    // Only one item is in flight: no item is taken right after another.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> !item.ready)
        else $error("item taken while another is in flight");
`endif

endmodule
